// ----- rtl/core/ps2_scancode_to_ascii_decoder_macros.svh -----
// Assertion macros for the scancode decoder RTL.
`ifndef PS2_SCANCODE_TO_ASCII_DECODER_MACROS_SVH
`define PS2_SCANCODE_TO_ASCII_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PS2SC_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("ps2sc assertion failed");

// Next-cycle implication, disabled during reset.
`define PS2SC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("ps2sc assertion failed");

`endif

// ----- rtl/core/ps2sc_pkg.sv -----
// Types, codes and scancode ROMs for the PS/2 scancode decoder.
package ps2sc_pkg;

  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_LEFT   = 3'd1;
  localparam logic [2:0] KIND_RIGHT  = 3'd2;
  localparam logic [2:0] KIND_DELETE = 3'd3;
  localparam logic [2:0] KIND_CMD    = 3'd4;

  localparam logic [7:0] SC_EXTENDED = 8'hE0;
  localparam logic [7:0] SC_PAUSE    = 8'hE1;
  localparam logic [6:0] SC_LSHIFT   = 7'h2A;
  localparam logic [6:0] SC_RSHIFT   = 7'h36;
  localparam logic [6:0] SC_CAPS     = 7'h3A;
  localparam logic [6:0] SC_NUM      = 7'h45;
  localparam logic [6:0] SC_SCROLL   = 7'h46;
  localparam logic [6:0] SC_PAD_LO   = 7'h47;
  localparam logic [6:0] SC_PAD_HI   = 7'h53;
  localparam logic [6:0] SC_PAD_STAR = 7'h37;

  localparam logic [7:0] LED_COMMAND = 8'hED;
  localparam logic [2:0] PAUSE_SKIP  = 3'd5;

  localparam logic [7:0] ASCII_FOUR = 8'h34;
  localparam logic [7:0] ASCII_SIX  = 8'h36;
  localparam logic [7:0] ASCII_DOT  = 8'h2E;

  typedef struct packed {
    logic [7:0] scan_byte;
  } scan_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] event_value;
    logic       last_of_run;
  } evt_item_t;

  typedef struct packed {
    logic       shift_held;
    logic       caps_lock_on;
    logic       num_lock_on;
    logic       scroll_lock_on;
    logic       awaiting_first_press;
    logic       extended_pending;
    logic [2:0] pause_bytes_left;
  } kbd_state_t;

  typedef struct packed {
    logic [1:0] count;
    evt_item_t  ev0;
    evt_item_t  ev1;
  } dec_out_t;

  function automatic logic [7:0] plain_rom(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h02: ch = 8'h31; 7'h03: ch = 8'h32; 7'h04: ch = 8'h33; 7'h05: ch = 8'h34;
      7'h06: ch = 8'h35; 7'h07: ch = 8'h36; 7'h08: ch = 8'h37; 7'h09: ch = 8'h38;
      7'h0A: ch = 8'h39; 7'h0B: ch = 8'h30; 7'h0C: ch = 8'h2D; 7'h0D: ch = 8'h3D;
      7'h0E: ch = 8'h08; 7'h0F: ch = 8'h09; 7'h10: ch = 8'h71; 7'h11: ch = 8'h77;
      7'h12: ch = 8'h65; 7'h13: ch = 8'h72; 7'h14: ch = 8'h74; 7'h15: ch = 8'h79;
      7'h16: ch = 8'h75; 7'h17: ch = 8'h69; 7'h18: ch = 8'h6F; 7'h19: ch = 8'h70;
      7'h1A: ch = 8'h5B; 7'h1B: ch = 8'h5D; 7'h1C: ch = 8'h0A; 7'h1E: ch = 8'h61;
      7'h1F: ch = 8'h73; 7'h20: ch = 8'h64; 7'h21: ch = 8'h66; 7'h22: ch = 8'h67;
      7'h23: ch = 8'h68; 7'h24: ch = 8'h6A; 7'h25: ch = 8'h6B; 7'h26: ch = 8'h6C;
      7'h27: ch = 8'h3B; 7'h28: ch = 8'h27; 7'h29: ch = 8'h60; 7'h2B: ch = 8'h5C;
      7'h2C: ch = 8'h7A; 7'h2D: ch = 8'h78; 7'h2E: ch = 8'h63; 7'h2F: ch = 8'h76;
      7'h30: ch = 8'h62; 7'h31: ch = 8'h6E; 7'h32: ch = 8'h6D; 7'h33: ch = 8'h2C;
      7'h34: ch = 8'h2E; 7'h35: ch = 8'h2F; 7'h37: ch = 8'h2A; 7'h39: ch = 8'h20;
      7'h47: ch = 8'h37; 7'h48: ch = 8'h38; 7'h49: ch = 8'h39; 7'h4A: ch = 8'h2D;
      7'h4B: ch = 8'h34; 7'h4C: ch = 8'h35; 7'h4D: ch = 8'h36; 7'h4E: ch = 8'h2B;
      7'h4F: ch = 8'h31; 7'h50: ch = 8'h32; 7'h51: ch = 8'h33; 7'h52: ch = 8'h30;
      7'h53: ch = 8'h2E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Keys with no shifted form fall back to the plain table.
  function automatic logic [7:0] shift_rom(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h02: ch = 8'h21; 7'h03: ch = 8'h40; 7'h04: ch = 8'h23; 7'h05: ch = 8'h24;
      7'h06: ch = 8'h25; 7'h07: ch = 8'h5E; 7'h08: ch = 8'h26; 7'h09: ch = 8'h2A;
      7'h0A: ch = 8'h28; 7'h0B: ch = 8'h29; 7'h0C: ch = 8'h5F; 7'h0D: ch = 8'h2B;
      7'h10: ch = 8'h51; 7'h11: ch = 8'h57; 7'h12: ch = 8'h45; 7'h13: ch = 8'h52;
      7'h14: ch = 8'h54; 7'h15: ch = 8'h59; 7'h16: ch = 8'h55; 7'h17: ch = 8'h49;
      7'h18: ch = 8'h4F; 7'h19: ch = 8'h50; 7'h1A: ch = 8'h7B; 7'h1B: ch = 8'h7D;
      7'h1E: ch = 8'h41; 7'h1F: ch = 8'h53; 7'h20: ch = 8'h44; 7'h21: ch = 8'h46;
      7'h22: ch = 8'h47; 7'h23: ch = 8'h48; 7'h24: ch = 8'h4A; 7'h25: ch = 8'h4B;
      7'h26: ch = 8'h4C; 7'h27: ch = 8'h3A; 7'h28: ch = 8'h22; 7'h29: ch = 8'h7E;
      7'h2B: ch = 8'h7C; 7'h2C: ch = 8'h5A; 7'h2D: ch = 8'h58; 7'h2E: ch = 8'h43;
      7'h2F: ch = 8'h56; 7'h30: ch = 8'h42; 7'h31: ch = 8'h4E; 7'h32: ch = 8'h4D;
      7'h33: ch = 8'h3C; 7'h34: ch = 8'h3E; 7'h35: ch = 8'h3F;
      default: ch = plain_rom(code);
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/core/ps2sc_stream_if.sv -----
// Valid/ready stream interface used for scancode input and event output.
interface ps2sc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/ps2sc_decode.sv -----
// Scancode decode: keyboard state update and up to two events per byte.
module ps2sc_decode
  import ps2sc_pkg::*;
(
  input  logic [7:0] scan_byte,
  input  kbd_state_t st,
  output kbd_state_t st_next,
  output dec_out_t   dec
);

  logic [6:0] code;
  logic       release_bit;
  logic       shift_key;
  logic       pad_key;
  logic [7:0] ext_ch;
  logic [7:0] ch;
  logic       led_run;

  assign code        = scan_byte[6:0];
  assign release_bit = scan_byte[7];
  assign shift_key   = (code == SC_LSHIFT) || (code == SC_RSHIFT);
  assign pad_key     = ((code >= SC_PAD_LO) && (code <= SC_PAD_HI)) || (code == SC_PAD_STAR);
  assign ext_ch      = plain_rom(code);

  // Caps lock swaps the case of letters only.
  always_comb begin
    ch = st.shift_held ? shift_rom(code) : plain_rom(code);
    if (st.caps_lock_on) begin
      if ((ch >= 8'h61) && (ch <= 8'h7A)) begin
        ch = ch - 8'd32;
      end else if ((ch >= 8'h41) && (ch <= 8'h5A)) begin
        ch = ch + 8'd32;
      end
    end
  end

  always_comb begin
    st_next = st;
    led_run = 1'b0;
    dec     = '0;
    if (st.pause_bytes_left != 3'd0) begin
      st_next.pause_bytes_left = st.pause_bytes_left - 3'd1;
    end else if (st.extended_pending) begin
      st_next.extended_pending = 1'b0;
      if (!release_bit) begin
        dec.ev0.last_of_run = 1'b1;
        case (ext_ch)
          ASCII_FOUR: begin
            dec.count         = 2'd1;
            dec.ev0.event_kind = KIND_LEFT;
          end
          ASCII_SIX: begin
            dec.count         = 2'd1;
            dec.ev0.event_kind = KIND_RIGHT;
          end
          ASCII_DOT: begin
            dec.count         = 2'd1;
            dec.ev0.event_kind = KIND_DELETE;
          end
          default: dec.count = 2'd0;
        endcase
      end
    end else if (release_bit) begin
      if (scan_byte == SC_EXTENDED) begin
        st_next.extended_pending = 1'b1;
      end else if (scan_byte == SC_PAUSE) begin
        st_next.pause_bytes_left = PAUSE_SKIP;
      end else if (shift_key) begin
        st_next.shift_held = 1'b0;
      end
    end else if (st.awaiting_first_press) begin
      st_next.awaiting_first_press = 1'b0;
    end else if (shift_key) begin
      st_next.shift_held = 1'b1;
    end else if (code == SC_CAPS) begin
      st_next.caps_lock_on = !st.caps_lock_on;
      led_run = 1'b1;
    end else if (code == SC_NUM) begin
      st_next.num_lock_on = !st.num_lock_on;
      led_run = 1'b1;
    end else if (code == SC_SCROLL) begin
      st_next.scroll_lock_on = !st.scroll_lock_on;
      led_run = 1'b1;
    end else if (!st.num_lock_on && pad_key) begin
      dec.count = 2'd0;
    end else if (ch != 8'h00) begin
      dec.count           = 2'd1;
      dec.ev0.event_kind  = KIND_CHAR;
      dec.ev0.event_value = ch;
      dec.ev0.last_of_run = 1'b1;
    end

    // The LED mask carries the flags after this key's toggle.
    if (led_run) begin
      dec.count           = 2'd2;
      dec.ev0.event_kind  = KIND_CMD;
      dec.ev0.event_value = LED_COMMAND;
      dec.ev0.last_of_run = 1'b0;
      dec.ev1.event_kind  = KIND_CMD;
      dec.ev1.event_value = {5'd0, st_next.caps_lock_on, st_next.num_lock_on,
                             st_next.scroll_lock_on};
      dec.ev1.last_of_run = 1'b1;
    end
  end

endmodule

// ----- rtl/core/ps2sc_evt_fifo.sv -----
// Small event queue: takes up to two events per cycle while it has room, hands out one when the sink is ready.
module ps2sc_evt_fifo
  import ps2sc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   push_n,
  input  evt_item_t    push0,
  input  evt_item_t    push1,
  output logic         room,
  ps2sc_stream_if.source evt
);

  `include "ps2_scancode_to_ascii_decoder_macros.svh"

  localparam int DEPTH = 4;

  evt_item_t  mem [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] cnt;
  logic       pop;

  assign pop         = evt.valid && evt.ready;
  assign evt.valid   = (cnt != 3'd0);
  assign evt.payload = mem[rd_ptr];
  // Room for a full two-event run regardless of what leaves this cycle.
  assign room        = (cnt <= 3'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      cnt    <= cnt + {1'b0, push_n} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push1;
    end
  end

  `PS2SC_ASSERT_IMPLIES(a_cnt_bound, clk, rst, 1'b1, cnt <= 3'(DEPTH))
  `PS2SC_ASSERT_IMPLIES(a_push_room, clk, rst, push_n != 2'd0, cnt <= 3'(DEPTH - 2))
  `PS2SC_ASSERT_NEXT(a_pop_only, clk, rst, pop && (push_n == 2'd0), cnt == $past(cnt) - 3'd1)

endmodule

// ----- rtl/core/ps2_scancode_to_ascii_decoder.sv -----
// PS/2 set-1 scancode to ASCII decoder, top level.
// A scancode is registered in s1_byte, decoded combinationally and written as
// events into the event queue. Throughput: one scancode per cycle while the queue
// has room; the queue drains one event per cycle while the sink is ready.
// Reset (synchronous, active high) clears all flags, empties the queue and arms
// the ignore-first-press flag.
module ps2_scancode_to_ascii_decoder
  import ps2sc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ps2sc_stream_if.sink   scan,
  ps2sc_stream_if.source evt
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_advance;
  logic       room;
  kbd_state_t kbd;
  kbd_state_t kbd_next;
  dec_out_t   dec;
  logic [1:0] push_n;

  assign s1_advance = s1_valid && room;
  assign scan.ready = !s1_valid || room;
  assign push_n     = s1_advance ? dec.count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      kbd      <= '{shift_held: 1'b0, caps_lock_on: 1'b0, num_lock_on: 1'b0,
                    scroll_lock_on: 1'b0, awaiting_first_press: 1'b1,
                    extended_pending: 1'b0, pause_bytes_left: 3'd0};
    end else begin
      if (scan.valid && scan.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        kbd <= kbd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      s1_byte <= scan.payload.scan_byte;
    end
  end

  ps2sc_decode u_decode (
    .scan_byte (s1_byte),
    .st        (kbd),
    .st_next   (kbd_next),
    .dec       (dec)
  );

  ps2sc_evt_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .push0  (dec.ev0),
    .push1  (dec.ev1),
    .room   (room),
    .evt    (evt)
  );

endmodule
